FILE: hdl/aes_pkg.sv
// ----------------------------------------------------------------------------
// aes_pkg
// Shared types, constants and GF(2^8) helpers for the AES block cipher.
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int NumLanes   = 4;
    localparam int MaxWords   = 60;
    localparam int NumRoundKeys = MaxWords / 4;
    localparam int WordIdxW   = 6;
    localparam int RoundW     = 4;

    localparam logic [1:0] KeyLen128 = 2'd0;
    localparam logic [1:0] KeyLen192 = 2'd1;

    localparam logic [2:0] RegKeyLength = 3'd0;
    localparam logic [2:0] RegKey0      = 3'd1;
    localparam logic [2:0] RegKey1      = 3'd2;
    localparam logic [2:0] RegKey2      = 3'd3;
    localparam logic [2:0] RegKey3      = 3'd4;

    localparam logic OpEncrypt = 1'b0;
    localparam logic OpDecrypt = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_ROUND,
        ST_FINAL,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic        decrypt;
        logic        first;
        logic        last;
    } t_lane_ctl;

    function automatic logic [7:0] gf_xtime(input logic [7:0] a);
        gf_xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        logic [7:0] x;
        p = 8'h00;
        x = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p = p ^ x;
            x = gf_xtime(x);
        end
        gf_mul = p;
    endfunction

    function automatic logic [7:0] gf_inv(input logic [7:0] a);
        logic [7:0] r;
        logic [7:0] b;
        r = 8'h01;
        b = a;
        for (int i = 0; i < 8; i++) begin
            if (i != 0) r = gf_mul(r, b);
            b = gf_mul(b, b);
        end
        gf_inv = r;
    endfunction

    function automatic logic [7:0] rotl8(input logic [7:0] x, input int n);
        rotl8 = 8'((x << n) | (x >> (8 - n)));
    endfunction

    function automatic logic [7:0] sbox_calc(input logic [7:0] x);
        logic [7:0] b;
        b = gf_inv(x);
        sbox_calc = b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4) ^ 8'h63;
    endfunction

    function automatic logic [7:0] inv_sbox_calc(input logic [7:0] x);
        inv_sbox_calc = gf_inv(rotl8(x, 1) ^ rotl8(x, 3) ^ rotl8(x, 6) ^ 8'h05);
    endfunction

    typedef logic [7:0] t_sbox [256];

    function automatic t_sbox build_sbox(input logic inverse);
        t_sbox t;
        for (int i = 0; i < 256; i++) begin
            t[i] = inverse ? inv_sbox_calc(8'(i)) : sbox_calc(8'(i));
        end
        build_sbox = t;
    endfunction

    localparam t_sbox SBOX     = build_sbox(1'b0);
    localparam t_sbox INV_SBOX = build_sbox(1'b1);

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

endpackage

FILE: hdl/aes_lane.sv
// ----------------------------------------------------------------------------
// aes_lane
// One column of the AES round: substitution (encrypt only), mixing and
// round-key add for the column picked after row shifting in the merge stage.
// ----------------------------------------------------------------------------
module aes_lane
    import aes_pkg::*;
(
    input  logic [31:0] i_col,
    input  logic [31:0] i_key,
    input  t_lane_ctl   i_ctl,
    output logic [31:0] o_col
);

    logic [7:0] s [4];
    logic [7:0] m [4];
    logic [7:0] k [4];
    logic [31:0] enc;
    logic [31:0] dec;

    // encrypt: sub, mix (skipped in last), add key
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            s[r] = SBOX[i_col[31 - 8*r -: 8]];
        end
        m[0] = gf_xtime(s[0] ^ s[1]) ^ s[1] ^ s[2] ^ s[3];
        m[1] = gf_xtime(s[1] ^ s[2]) ^ s[0] ^ s[2] ^ s[3];
        m[2] = gf_xtime(s[2] ^ s[3]) ^ s[0] ^ s[1] ^ s[3];
        m[3] = gf_xtime(s[3] ^ s[0]) ^ s[0] ^ s[1] ^ s[2];
        if (i_ctl.last) begin
            enc = {s[0], s[1], s[2], s[3]} ^ i_key;
        end else begin
            enc = {m[0], m[1], m[2], m[3]} ^ i_key;
        end
    end

    // decrypt: input already inverse-substituted; add key, inverse mix
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            k[r] = i_col[31 - 8*r -: 8] ^ i_key[31 - 8*r -: 8];
        end
        if (i_ctl.last) begin
            dec = {k[0], k[1], k[2], k[3]};
        end else begin
            dec = {gf_mul(8'h0e, k[0]) ^ gf_mul(8'h0b, k[1]) ^ gf_mul(8'h0d, k[2])
                       ^ gf_mul(8'h09, k[3]),
                   gf_mul(8'h09, k[0]) ^ gf_mul(8'h0e, k[1]) ^ gf_mul(8'h0b, k[2])
                       ^ gf_mul(8'h0d, k[3]),
                   gf_mul(8'h0d, k[0]) ^ gf_mul(8'h09, k[1]) ^ gf_mul(8'h0e, k[2])
                       ^ gf_mul(8'h0b, k[3]),
                   gf_mul(8'h0b, k[0]) ^ gf_mul(8'h0d, k[1]) ^ gf_mul(8'h09, k[2])
                       ^ gf_mul(8'h0e, k[3])};
        end
    end

    assign o_col = i_ctl.first ? (i_col ^ i_key) : (i_ctl.decrypt ? dec : enc);

endmodule

FILE: hdl/aes_key_sched.sv
// ----------------------------------------------------------------------------
// aes_key_sched
// Round-key store and expander: one schedule word per cycle into a 15-entry
// store of 128-bit round keys, one registered round key read per cycle.
// ----------------------------------------------------------------------------
module aes_key_sched
    import aes_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [1:0]          i_key_length,
    input  logic [255:0]        i_key,
    input  logic [RoundW-1:0]   i_round,
    output logic                o_done,
    output logic [127:0]        o_round_key
);

    logic [127:0] r_rk [NumRoundKeys];
    logic        r_busy;
    logic [WordIdxW-1:0] r_idx;
    logic [2:0]  r_mod;
    logic [7:0]  r_rcon;
    logic [31:0] r_win [8];
    logic [WordIdxW-1:0] nk;
    logic [WordIdxW-1:0] total;
    logic [31:0] t;
    logic [31:0] n_word;
    logic [2:0]  nk_m1;

    assign nk    = (i_key_length == KeyLen128) ? 6'd4 :
                   (i_key_length == KeyLen192) ? 6'd6 : 6'd8;
    assign nk_m1 = 3'(nk - 6'd1);
    assign total = 6'(4 * (7 + 32'(nk)));

    // r_win holds the last nk words, newest in slot 0
    always_comb begin
        t = r_win[0];
        if (r_mod == 3'd0) begin
            t = sub_word({t[23:0], t[31:24]}) ^ {r_rcon, 24'h0};
        end else if (nk == 6'd8 && r_mod == 3'd4) begin
            t = sub_word(t);
        end
        n_word = r_win[nk_m1] ^ t;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_idx  <= nk;
                r_mod  <= 3'd0;
                r_rcon <= 8'h01;
                for (int i = 0; i < 8; i++) begin
                    r_win[i] <= (i < nk) ? i_key[255 - 32*(32'(nk) - 1 - i) -: 32] : 32'h0;
                end
            end else if (r_busy) begin
                if (r_idx == total - 6'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
                r_idx <= r_idx + 6'd1;
                r_mod <= (r_mod == nk_m1) ? 3'd0 : r_mod + 3'd1;
                if (r_mod == 3'd0) r_rcon <= gf_xtime(r_rcon);
                r_win[0] <= n_word;
                for (int i = 1; i < 8; i++) begin
                    r_win[i] <= r_win[i-1];
                end
            end
        end
    end

    // key words go in up front, derived words one per cycle into their column
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rk[0] <= i_key[255:128];
            r_rk[1] <= i_key[127:0];
        end else if (r_busy) begin
            r_rk[r_idx[5:2]][127 - 32*r_idx[1:0] -: 32] <= n_word;
        end
    end

    always_ff @(posedge i_clk) begin
        o_round_key <= r_rk[i_round];
    end

endmodule

FILE: hdl/aes_block_cipher.sv
// ----------------------------------------------------------------------------
// aes_block_cipher
// AES-128/192/256 encrypt and decrypt engine with stored key schedule.
// ----------------------------------------------------------------------------
// One block at a time. After a key change the first block waits for the
// schedule expansion, one word per cycle. A block then runs each round as
// a round-key read, then one full round in four column lanes; the next
// block can be taken in the cycle in which the result appears on the output.
// The result is held on the output until taken; a block in flight finishes
// its rounds meanwhile and waits in its final stage for the output to free.
module aes_block_cipher
    import aes_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_stall,
    input  logic         i_opcode,
    input  logic [63:0]  i_block_hi,
    input  logic [63:0]  i_block_lo,
    output logic         o_valid,
    input  logic         i_stall,
    output logic [63:0]  o_result_hi,
    output logic [63:0]  o_result_lo,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_index,
    input  logic [63:0]  i_cfg_data
);

    t_state r_state, n_state;
    logic [1:0]   r_key_length;
    logic [255:0] r_key;
    logic         r_ready;
    logic         r_dec;
    logic         r_phase;
    logic [RoundW-1:0] r_round;
    logic [RoundW-1:0] rounds;
    logic [7:0]   r_s [16];
    logic         r_out_valid;
    logic         accept;
    logic         ks_start, ks_done;
    logic [127:0] rkey;
    logic [31:0]  lane_in  [NumLanes];
    logic [31:0]  lane_out [NumLanes];
    t_lane_ctl    ctl;
    logic         out_take;

    assign rounds   = (r_key_length == KeyLen128) ? 4'd10 :
                      (r_key_length == KeyLen192) ? 4'd12 : 4'd14;
    assign out_take = r_out_valid && !i_stall;
    assign o_stall  = (r_state != ST_IDLE);
    assign accept   = i_valid && !o_stall;
    assign o_valid  = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_length <= 2'd0;
            r_key        <= '0;
            r_ready      <= 1'b0;
        end else begin
            if (ks_done) r_ready <= 1'b1;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    RegKeyLength: begin r_key_length <= i_cfg_data[1:0]; r_ready <= 1'b0; end
                    RegKey0: begin r_key[255:192] <= i_cfg_data; r_ready <= 1'b0; end
                    RegKey1: begin r_key[191:128] <= i_cfg_data; r_ready <= 1'b0; end
                    RegKey2: begin r_key[127:64]  <= i_cfg_data; r_ready <= 1'b0; end
                    RegKey3: begin r_key[63:0]    <= i_cfg_data; r_ready <= 1'b0; end
                    default: ;
                endcase
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (accept) n_state = r_ready ? ST_ROUND : ST_EXPAND;
            ST_EXPAND: if (ks_done) n_state = ST_ROUND;
            ST_ROUND:  if (r_phase && ((r_dec && r_round == 4'd0) ||
                                       (!r_dec && r_round == rounds))) n_state = ST_FINAL;
            ST_FINAL:  if (!r_out_valid || !i_stall) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // outputs of the controller
    always_comb begin
        ks_start = (r_state == ST_IDLE) && accept && !r_ready;
    end

    aes_key_sched u_ks (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (ks_start),
        .i_key_length (r_key_length),
        .i_key        (r_key),
        .i_round      (r_round),
        .o_done       (ks_done),
        .o_round_key  (rkey)
    );

    // merge: row shift feeds the lanes; decrypt applies inverse shift+sub first
    always_comb begin
        ctl.decrypt = r_dec;
        ctl.first   = r_dec ? (r_round == rounds) : (r_round == 4'd0);
        ctl.last    = r_dec ? (r_round == 4'd0)   : (r_round == rounds);
        for (int c = 0; c < NumLanes; c++) begin
            for (int r = 0; r < 4; r++) begin
                if (ctl.first) begin
                    lane_in[c][31 - 8*r -: 8] = r_s[4*c + r];
                end else if (r_dec) begin
                    lane_in[c][31 - 8*r -: 8] = INV_SBOX[r_s[4*((c + 4 - r) % 4) + r]];
                end else begin
                    lane_in[c][31 - 8*r -: 8] = r_s[4*((c + r) % 4) + r];
                end
            end
        end
    end

    for (genvar g = 0; g < NumLanes; g++) begin : g_lane
        aes_lane u_lane (
            .i_col (lane_in[g]),
            .i_key (rkey[127 - 32*g -: 32]),
            .i_ctl (ctl),
            .o_col (lane_out[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_take) r_out_valid <= 1'b0;
            if (r_state == ST_FINAL && n_state == ST_IDLE) r_out_valid <= 1'b1;
            if (r_state == ST_ROUND) begin
                r_phase <= !r_phase;
                if (r_phase) r_round <= r_dec ? r_round - 4'd1 : r_round + 4'd1;
            end else begin
                r_phase <= 1'b0;
            end
            if (accept) begin
                r_dec   <= (i_opcode == OpDecrypt);
                r_round <= (i_opcode == OpDecrypt) ? rounds : 4'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int i = 0; i < 8; i++) begin
                r_s[i]     <= i_block_hi[63 - 8*i -: 8];
                r_s[8 + i] <= i_block_lo[63 - 8*i -: 8];
            end
        end else if (r_state == ST_ROUND && r_phase) begin
            for (int c = 0; c < NumLanes; c++) begin
                for (int r = 0; r < 4; r++) begin
                    r_s[4*c + r] <= lane_out[c][31 - 8*r -: 8];
                end
            end
        end
        if (r_state == ST_FINAL && n_state == ST_IDLE) begin
            for (int i = 0; i < 8; i++) begin
                o_result_hi[63 - 8*i -: 8] <= r_s[i];
                o_result_lo[63 - 8*i -: 8] <= r_s[8 + i];
            end
        end
    end

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !accept) else $error("beat taken while busy");
    a_expand_only_stale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ks_start |-> !r_ready) else $error("expansion with ready schedule");
    a_round_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND) |-> (r_round <= rounds)) else $error("round overrun");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> r_out_valid) else $error("result dropped");

endmodule
